// ===== hdl/bhba_pkg.sv =====
// Package with the sizes shared by the bucket accumulator files.
`default_nettype none
package bhba_pkg;
    localparam int BUCKETS     = 64;
    localparam int IDX_W       = $clog2(BUCKETS);
    localparam int STACK_DEPTH = 64;
    localparam int STK_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STK_W + 1;
    localparam int DOC_W       = 31;
    localparam int DATA_W      = 32;
    localparam int HITS_W      = 6;
    localparam int COORD_W     = 6;
    localparam int PROD_W      = DATA_W + HITS_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROHIBITED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COORD  = 2'd2;

    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/bhba_if.sv =====
// Handshake interfaces for the hit, result and configuration channels.
`default_nettype none
interface bhba_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [bhba_pkg::DOC_W-1:0]    doc_id;
    logic [bhba_pkg::DATA_W-1:0]   hit_score;
    logic [bhba_pkg::DATA_W-1:0]   clause_bit;
    modport source (output valid, opcode, doc_id, hit_score, clause_bit, input ready);
    modport sink   (input valid, opcode, doc_id, hit_score, clause_bit, output ready);
endinterface

interface bhba_out_if;
    logic                          valid;
    logic                          ready;
    logic [bhba_pkg::DOC_W-1:0]    out_doc;
    logic [bhba_pkg::DATA_W-1:0]   out_score;
    logic                          hit_valid;
    logic                          last;
    modport source (output valid, out_doc, out_score, hit_valid, last, input ready);
    modport sink   (input valid, out_doc, out_score, hit_valid, last, output ready);
endinterface

interface bhba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bhba_pkg::CFG_IDX_W-1:0]  index;
    logic [bhba_pkg::DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/boolean_hit_bucket_accumulator_unit.sv =====
// Boolean hit bucket accumulator: bucket table, open stack and flush scorer.
// A hit beat is accepted with a registered read of the bucket table, then written back.
// A flush walks the open stack from the top, reading the stack entry and then the bucket
// (S_ORD, S_BKT) and checking it (S_CHK); each accepted bucket then takes a multiply step,
// the restoring divider (one quotient bit per cycle) and an emit step, and a final step
// sends the last result and clears the table. The input is ready only while idle.
`default_nettype none
module boolean_hit_bucket_accumulator_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bhba_in_if.sink     hit_in,
    bhba_out_if.source  result_out,
    bhba_cfg_if.sink    cfg
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HIT   = 4'd1;
    localparam logic [3:0] S_ORD   = 4'd2;
    localparam logic [3:0] S_BKT   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam int DIV_CW = $clog2(bhba_pkg::PROD_W + 1);

    logic [3:0] state_reg, state_next;

    logic [bhba_pkg::DATA_W-1:0]  req_reg, proh_reg;
    logic [bhba_pkg::COORD_W-1:0] coord_reg;

    logic [bhba_pkg::DOC_W-1:0]   tag_mem   [bhba_pkg::BUCKETS];
    logic [bhba_pkg::DATA_W-1:0]  sum_mem   [bhba_pkg::BUCKETS];
    logic [bhba_pkg::DATA_W-1:0]  bits_mem  [bhba_pkg::BUCKETS];
    logic [bhba_pkg::HITS_W-1:0]  count_mem [bhba_pkg::BUCKETS];
    logic [bhba_pkg::IDX_W-1:0]   order_mem [bhba_pkg::STACK_DEPTH];

    logic [bhba_pkg::BUCKETS-1:0] valid_reg, listed_reg;
    logic [bhba_pkg::CNT_W-1:0]   open_cnt_reg, k_reg;

    logic [bhba_pkg::DOC_W-1:0]   tag_rd_reg;
    logic [bhba_pkg::DATA_W-1:0]  sum_rd_reg, bits_rd_reg;
    logic [bhba_pkg::HITS_W-1:0]  count_rd_reg;
    logic [bhba_pkg::IDX_W-1:0]   ord_rd_reg;

    logic [bhba_pkg::DOC_W-1:0]   doc_reg;
    logic [bhba_pkg::DATA_W-1:0]  score_reg, bit_reg;

    logic [bhba_pkg::PROD_W-1:0]  dvd_reg;
    logic [bhba_pkg::COORD_W-1:0] rem_reg;
    logic [DIV_CW-1:0]            div_cnt_reg;

    logic                         pend_v_reg;
    logic [bhba_pkg::DOC_W-1:0]   pend_doc_reg;
    logic [bhba_pkg::DATA_W-1:0]  pend_score_reg;

    logic                         out_v_reg, out_hv_reg, out_last_reg;
    logic [bhba_pkg::DOC_W-1:0]   out_doc_reg;
    logic [bhba_pkg::DATA_W-1:0]  out_score_reg;

    logic [bhba_pkg::IDX_W-1:0]   rd_addr, hit_idx;
    logic [bhba_pkg::STK_W-1:0]   ord_addr;
    logic                         in_acc, out_free, out_load, match, push_ok, accept_bkt;
    logic [bhba_pkg::DATA_W:0]    sum_wide;
    logic [bhba_pkg::COORD_W-1:0] divisor;
    logic [bhba_pkg::COORD_W:0]   rem_try;
    logic [bhba_pkg::DATA_W-1:0]  quot_sat;

    assign hit_in.ready = (state_reg == S_IDLE);
    assign in_acc       = hit_in.valid && hit_in.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_v_reg || result_out.ready;
    assign out_load     = (state_reg == S_EMIT && pend_v_reg && out_free)
                          || (state_reg == S_FIN && out_free);

    assign hit_idx  = doc_reg[bhba_pkg::IDX_W-1:0];
    assign rd_addr  = (state_reg == S_IDLE) ? hit_in.doc_id[bhba_pkg::IDX_W-1:0] : ord_rd_reg;
    assign ord_addr = bhba_pkg::STK_W'(k_reg - 1'b1);
    assign match    = valid_reg[hit_idx] && (tag_rd_reg == doc_reg);
    assign push_ok  = listed_reg[hit_idx]
                      || (open_cnt_reg < bhba_pkg::CNT_W'(bhba_pkg::STACK_DEPTH));
    assign sum_wide = {1'b0, sum_rd_reg} + {1'b0, score_reg};
    assign accept_bkt = valid_reg[ord_rd_reg] && ((bits_rd_reg & proh_reg) == '0)
                        && ((bits_rd_reg & req_reg) == req_reg);
    assign divisor  = (coord_reg == '0) ? bhba_pkg::COORD_W'(1) : coord_reg;
    assign rem_try  = {rem_reg, dvd_reg[bhba_pkg::PROD_W-1]};
    assign quot_sat = (dvd_reg[bhba_pkg::PROD_W-1:bhba_pkg::DATA_W] != '0)
                      ? '1 : dvd_reg[bhba_pkg::DATA_W-1:0];

    // Table and stack storage; reads are registered every cycle.
    always_ff @(posedge clk)
    begin
        tag_rd_reg   <= tag_mem[rd_addr];
        sum_rd_reg   <= sum_mem[rd_addr];
        bits_rd_reg  <= bits_mem[rd_addr];
        count_rd_reg <= count_mem[rd_addr];
        ord_rd_reg   <= order_mem[ord_addr];
        if (state_reg == S_HIT)
        begin
            if (match)
            begin
                sum_mem[hit_idx]  <= sum_wide[bhba_pkg::DATA_W] ? '1
                                     : sum_wide[bhba_pkg::DATA_W-1:0];
                bits_mem[hit_idx] <= bits_rd_reg | bit_reg;
                if (count_rd_reg != '1)
                begin
                    count_mem[hit_idx] <= count_rd_reg + 1'b1;
                end
            end
            else if (push_ok)
            begin
                tag_mem[hit_idx]   <= doc_reg;
                sum_mem[hit_idx]   <= score_reg;
                bits_mem[hit_idx]  <= bit_reg;
                count_mem[hit_idx] <= bhba_pkg::HITS_W'(1);
                if (!listed_reg[hit_idx])
                begin
                    order_mem[open_cnt_reg[bhba_pkg::STK_W-1:0]] <= hit_idx;
                end
            end
        end
    end

    // Payload registers for the hit, the divider and the pending result.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            doc_reg   <= hit_in.doc_id;
            score_reg <= hit_in.hit_score;
            bit_reg   <= hit_in.clause_bit;
        end
        if (state_reg == S_CHK)
        begin
            doc_reg <= tag_rd_reg;
        end
        if (state_reg == S_MUL)
        begin
            dvd_reg <= bhba_pkg::PROD_W'(sum_rd_reg) * bhba_pkg::PROD_W'(count_rd_reg);
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            if (rem_try >= {1'b0, divisor})
            begin
                rem_reg <= bhba_pkg::COORD_W'(rem_try - {1'b0, divisor});
                dvd_reg <= {dvd_reg[bhba_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try[bhba_pkg::COORD_W-1:0];
                dvd_reg <= {dvd_reg[bhba_pkg::PROD_W-2:0], 1'b0};
            end
        end
        if (state_reg == S_EMIT && (!pend_v_reg || out_free))
        begin
            pend_doc_reg   <= doc_reg;
            pend_score_reg <= quot_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (hit_in.opcode == bhba_pkg::OP_HIT)
                        state_next = S_HIT;
                    else if (open_cnt_reg == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_ORD;
                end
            end
            S_HIT:  state_next = S_IDLE;
            S_ORD:  state_next = S_BKT;
            S_BKT:  state_next = S_CHK;
            S_CHK:
            begin
                if (accept_bkt)
                    state_next = S_MUL;
                else if (k_reg == bhba_pkg::CNT_W'(1))
                    state_next = S_FIN;
                else
                    state_next = S_ORD;
            end
            S_MUL:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CW'(bhba_pkg::PROD_W - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!pend_v_reg || out_free)
                    state_next = (k_reg == bhba_pkg::CNT_W'(1)) ? S_FIN : S_ORD;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            req_reg      <= '0;
            proh_reg     <= '0;
            coord_reg    <= bhba_pkg::COORD_W'(1);
            valid_reg    <= '0;
            listed_reg   <= '0;
            open_cnt_reg <= '0;
            k_reg        <= '0;
            div_cnt_reg  <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_hv_reg   <= 1'b0;
            out_last_reg <= 1'b0;
            out_doc_reg  <= '0;
            out_score_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    bhba_pkg::REG_REQUIRED:   req_reg   <= cfg.data;
                    bhba_pkg::REG_PROHIBITED: proh_reg  <= cfg.data;
                    bhba_pkg::REG_MAX_COORD:  coord_reg <= cfg.data[bhba_pkg::COORD_W-1:0];
                    default: ;
                endcase
            end
            if (out_v_reg && result_out.ready && !out_load)
            begin
                out_v_reg <= 1'b0;
            end
            if (in_acc)
            begin
                k_reg <= open_cnt_reg;
            end
            if (state_reg == S_HIT && !match && push_ok)
            begin
                valid_reg[hit_idx] <= 1'b1;
                if (!listed_reg[hit_idx])
                begin
                    listed_reg[hit_idx] <= 1'b1;
                    open_cnt_reg <= open_cnt_reg + 1'b1;
                end
            end
            if (state_reg == S_CHK && !accept_bkt)
            begin
                k_reg <= k_reg - 1'b1;
            end
            div_cnt_reg <= (state_reg == S_DIV) ? div_cnt_reg + 1'b1 : '0;
            if (state_reg == S_EMIT && (!pend_v_reg || out_free))
            begin
                // The held result is not the last one, since another follows it.
                if (pend_v_reg)
                begin
                    out_v_reg     <= 1'b1;
                    out_doc_reg   <= pend_doc_reg;
                    out_score_reg <= pend_score_reg;
                    out_hv_reg    <= 1'b1;
                    out_last_reg  <= 1'b0;
                end
                pend_v_reg <= 1'b1;
                k_reg      <= k_reg - 1'b1;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_v_reg     <= 1'b1;
                out_doc_reg   <= pend_v_reg ? pend_doc_reg : '0;
                out_score_reg <= pend_v_reg ? pend_score_reg : '0;
                out_hv_reg    <= pend_v_reg;
                out_last_reg  <= 1'b1;
                pend_v_reg    <= 1'b0;
                valid_reg     <= '0;
                listed_reg    <= '0;
                open_cnt_reg  <= '0;
            end
        end
    end

    assign result_out.valid     = out_v_reg;
    assign result_out.out_doc   = out_doc_reg;
    assign result_out.out_score = out_score_reg;
    assign result_out.hit_valid = out_hv_reg;
    assign result_out.last      = out_last_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_cnt_reg <= bhba_pkg::CNT_W'(bhba_pkg::STACK_DEPTH))
        else $error("open stack count beyond its depth");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (open_cnt_reg == '0 && valid_reg == '0))
        else $error("flush did not empty the table");
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> ($past(state_reg) == S_DIV))
        else $error("divider counting outside a division");
    a_hit_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && hit_in.opcode == bhba_pkg::OP_HIT) |=> (state_reg == S_HIT))
        else $error("hit beat did not enter the update step");
endmodule
`default_nettype wire
